>>> src/chunkrx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunkrx_pkg
// Shared types, constants and the CRC-32 byte update for the chunk receiver.
// ----------------------------------------------------------------------------
package chunkrx_pkg;

   localparam int unsigned HdrBytes  = 8;
   localparam int unsigned PosWidth  = 9;
   localparam logic [PosWidth-1:0] PosMax = '1;
   localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
   localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
   localparam logic [23:0] TotalMax  = 24'hFF_FFFF;
   localparam logic [15:0] MagicReset     = 16'hF17E;
   localparam logic [7:0]  ChunkSizeReset = 8'd48;

   typedef enum logic [2:0] {
      VERDICT_NEW       = 3'd0,
      VERDICT_DUPLICATE = 3'd1,
      VERDICT_COMPLETE  = 3'd2,
      VERDICT_SHORT     = 3'd3,
      VERDICT_BAD_MAGIC = 3'd4,
      VERDICT_BAD_LEN   = 3'd5,
      VERDICT_BAD_SUM   = 3'd6,
      VERDICT_ORDER     = 3'd7
   } verdict_type;

   typedef enum logic {
      CSR_EXPECTED_MAGIC = 1'b0,
      CSR_CHUNK_SIZE     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        send_ack;
      logic [15:0] ack_chunk;
      logic [23:0] write_offset;
      logic        transfer_done;
      logic [31:0] image_crc;
      logic [23:0] image_size;
      logic [15:0] chunks_received;
   } rsp_type;

   typedef struct packed {
      logic [15:0] expected_magic;
      logic [7:0]  chunk_bytes;
   } csr_type;

   typedef struct packed {
      logic valid;
      logic out_free;
   } core_ctl_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> src/chunkrx_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunkrx_in_reg
// Input register stage: holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module chunkrx_in_reg
   import chunkrx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    take,
   output logic    in_valid,
   output req_type in_data
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    accept;

   assign req_stall = valid_ff & ~take;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = accept | (valid_ff & ~take);
      data_in  = accept ? req_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

>>> src/chunkrx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunkrx_core
// Header parse, payload XOR/CRC, and end-of-packet verdict with commit.
// ----------------------------------------------------------------------------
module chunkrx_core
   import chunkrx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  core_ctl_type ctl,
   input  req_type      in_data,
   input  csr_type      csr,
   output logic         take,
   output logic         rsp_load,
   output rsp_type      rsp_next
);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [15:0] magic_ff, magic_in;
   logic [15:0] chunk_ff, chunk_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  xor_ff, xor_in;
   logic [31:0] crc_t_ff, crc_t_in;
   logic [31:0] crc_c_ff, crc_c_in;
   logic [15:0] next_ff, next_in;
   logic [15:0] unique_ff, unique_in;
   logic [23:0] bytes_ff, bytes_in;
   logic [15:0] announced_ff, announced_in;
   logic        done_ff, done_in;

   logic [PosWidth-1:0] count;
   logic [7:0]  b;
   logic        last;
   logic [24:0] bytes_sum;
   verdict_type verdict;
   logic        ack;
   logic [15:0] ack_chunk;
   logic [23:0] offset;

   assign b    = in_data.packet_byte;
   assign last = in_data.end_of_packet;
   assign take = ctl.valid & (~last | ctl.out_free);

   always_comb begin
      magic_in     = magic_ff;
      chunk_in     = chunk_ff;
      total_in     = total_ff;
      length_in    = length_ff;
      sum_in       = sum_ff;
      xor_in       = xor_ff;
      crc_t_in     = crc_t_ff;
      crc_c_in     = crc_c_ff;
      next_in      = next_ff;
      unique_in    = unique_ff;
      bytes_in     = bytes_ff;
      announced_in = announced_ff;
      done_in      = done_ff;
      pos_in       = pos_ff;
      verdict      = VERDICT_SHORT;
      ack          = 1'b0;
      ack_chunk    = 16'd0;
      offset       = 24'd0;
      bytes_sum    = {1'b0, bytes_ff} + {17'd0, length_ff};

      if (take) begin
         case (pos_ff)
            9'd0:    magic_in  = {b, 8'd0};
            9'd1:    magic_in  = {magic_ff[15:8], b};
            9'd2:    chunk_in  = {b, 8'd0};
            9'd3:    chunk_in  = {chunk_ff[15:8], b};
            9'd4:    total_in  = {b, 8'd0};
            9'd5:    total_in  = {total_ff[15:8], b};
            9'd6:    length_in = b;
            9'd7:    sum_in    = b;
            default: begin
               xor_in   = xor_ff ^ b;
               crc_t_in = crc_byte(crc_t_ff, b);
            end
         endcase
      end

      count = (pos_ff < PosMax) ? pos_ff + 1'b1 : PosMax;

      if (take && !last) begin
         pos_in = count;
      end else if (take) begin
         if (count >= PosWidth'(HdrBytes)) begin
            ack_chunk = chunk_in;
            offset    = 24'(chunk_in) * 24'(csr.chunk_bytes);
            if (magic_in != csr.expected_magic) begin
               verdict = VERDICT_BAD_MAGIC;
            end else if ({1'b0, count} != 10'(HdrBytes) + {2'd0, length_in}) begin
               verdict = VERDICT_BAD_LEN;
            end else if (xor_in != sum_in) begin
               verdict = VERDICT_BAD_SUM;
            end else if (done_ff) begin
               verdict = VERDICT_COMPLETE;
               ack     = 1'b1;
            end else if (chunk_in < next_ff) begin
               verdict = VERDICT_DUPLICATE;
               ack     = 1'b1;
            end else if (chunk_in != next_ff) begin
               verdict = VERDICT_ORDER;
            end else begin
               verdict      = VERDICT_NEW;
               ack          = 1'b1;
               crc_c_in     = crc_t_in;
               unique_in    = unique_ff + 16'd1;
               next_in      = next_ff + 16'd1;
               bytes_in     = bytes_sum[24] ? TotalMax : bytes_sum[23:0];
               announced_in = total_in;
               if (unique_in >= total_in) begin
                  done_in = 1'b1;
               end
            end
         end
         pos_in   = '0;
         xor_in   = 8'd0;
         crc_t_in = crc_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         magic_ff     <= 16'd0;
         chunk_ff     <= 16'd0;
         total_ff     <= 16'd0;
         length_ff    <= 8'd0;
         sum_ff       <= 8'd0;
         xor_ff       <= 8'd0;
         crc_t_ff     <= CrcInit;
         crc_c_ff     <= CrcInit;
         next_ff      <= 16'd0;
         unique_ff    <= 16'd0;
         bytes_ff     <= 24'd0;
         announced_ff <= 16'd0;
         done_ff      <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         magic_ff     <= magic_in;
         chunk_ff     <= chunk_in;
         total_ff     <= total_in;
         length_ff    <= length_in;
         sum_ff       <= sum_in;
         xor_ff       <= xor_in;
         crc_t_ff     <= crc_t_in;
         crc_c_ff     <= crc_c_in;
         next_ff      <= next_in;
         unique_ff    <= unique_in;
         bytes_ff     <= bytes_in;
         announced_ff <= announced_in;
         done_ff      <= done_in;
      end
   end

   assign rsp_load = take & last;

   always_comb begin
      rsp_next.verdict         = verdict;
      rsp_next.send_ack        = ack;
      rsp_next.ack_chunk       = ack_chunk;
      rsp_next.write_offset    = offset;
      rsp_next.transfer_done   = done_in;
      rsp_next.image_crc       = ~crc_c_in;
      rsp_next.image_size      = bytes_in;
      rsp_next.chunks_received = unique_in;
   end

endmodule

>>> src/chunkrx_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunkrx_out_reg
// Result register: holds one verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module chunkrx_out_reg
   import chunkrx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    out_free,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign out_free = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = load | (valid_ff & rsp_stall);
      data_in  = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> src/chunk_receiver_with_crc32_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_receiver_with_crc32_top
// Stop-and-wait chunk receiver with XOR check and running CRC-32.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while req_stall is low, with no gaps
// between packets. Each byte is registered, then parsed and folded into the
// XOR and CRC-32 (one unrolled byte update) by the core; on the final byte
// the verdict is formed combinationally and lands in the result register,
// which drives rsp_valid. One response is emitted per packet; the result
// register lets the next packet stream in while a response is stalled, and
// only a second final byte waits.
// Write the CSRs only while no packet is in flight.
module chunk_receiver_with_crc32_top
   import chunkrx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   csr_type      csr_ff, csr_in;
   core_ctl_type ctl;
   logic         in_valid;
   req_type      in_data;
   logic         take;
   logic         rsp_load;
   rsp_type      rsp_next;
   logic         out_free;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_EXPECTED_MAGIC: csr_in.expected_magic = csr_write_data;
            CSR_CHUNK_SIZE:     csr_in.chunk_bytes    = csr_write_data[7:0];
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.expected_magic <= MagicReset;
         csr_ff.chunk_bytes    <= ChunkSizeReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   chunkrx_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .take      (take),
      .in_valid  (in_valid),
      .in_data   (in_data)
   );

   assign ctl.valid    = in_valid;
   assign ctl.out_free = out_free;

   chunkrx_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .in_data  (in_data),
      .csr      (csr_ff),
      .take     (take),
      .rsp_load (rsp_load),
      .rsp_next (rsp_next)
   );

   chunkrx_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_next),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
